FILE: src/circular_queue_with_search_top_macros.svh
// Assertion macros shared by the queue controller and datapath.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define CQS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CQS_ASSERT(lbl, clk, rst, prop, msg)
`define CQS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: src/cqs_pkg.sv
// Types and constants shared by the circular queue with search.
`timescale 1ns / 1ps
package cqs_pkg;

  localparam int CNT_W  = 7;
  localparam int FUNC_W = 3;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [FUNC_W-1:0] FN_ENQ    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [SLOT_W-1:0]        found_slot;
    logic [CNT_W-1:0]         count;
    logic                     is_full;
    logic                     is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              wr_enq;
    logic              rd_head;
    logic              deq;
    logic              clear;
    logic              scan_start;
    logic              scan;
    logic              load_out;
    logic [STAT_W-1:0] out_status;
    logic              out_data_sel;
    logic              out_slot_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              scan_hit;
    logic              scan_end;
  } dp_stat_t;

endpackage

FILE: src/cqs_dp.sv
// Datapath of the circular queue: storage ring, pointers, search scan and result register.
`timescale 1ns / 1ps
`include "circular_queue_with_search_top_macros.svh"
module cqs_dp import cqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CNT_W-1:0]     cfg_wdata,
  input  req_t                 in_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output rsp_t                 out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int AW = ((PW > CNT_W) ? PW : CNT_W) + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  eff_cap;
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [CNT_W-1:0]  held;
  req_t              req;
  logic [PW-1:0]     scan_ptr;
  logic [CNT_W-1:0]  issue_left;
  logic              rd_v;
  logic [PW-1:0]     rd_slot;
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [PW-1:0]     rd_addr;
  logic              scan_issue;
  logic              scan_hit;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CNT_W-1:0] c);
    logic [AW-1:0] n;
    n = AW'(p) + AW'(1);
    if (n >= AW'(c)) begin
      adv = '0;
    end else begin
      adv = PW'(n);
    end
  endfunction

  // Capacity is clamped to one slot at the low end and to the built depth above.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = capacity;
    end
  end

  assign scan_hit   = rd_v && (rd_data == req.value);
  assign scan_issue = cmd.scan && !scan_hit && (issue_left != '0);
  assign rd_en      = cmd.rd_head || scan_issue;
  assign rd_addr    = cmd.scan ? scan_ptr : head;

  assign stat.func     = req.func;
  assign stat.full     = (held == eff_cap);
  assign stat.empty    = (held == '0);
  assign stat.scan_hit = scan_hit;
  assign stat.scan_end = (issue_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      held     <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      head     <= '0;
      tail     <= '0;
      held     <= '0;
    end else if (cmd.clear) begin
      head <= '0;
      tail <= '0;
      held <= '0;
    end else if (cmd.wr_enq) begin
      tail <= adv(tail, eff_cap);
      held <= held + CNT_W'(1);
    end else if (cmd.deq) begin
      head <= adv(head, eff_cap);
      held <= held - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_enq) begin
      mem[tail] <= req.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_slot <= rd_addr;
    end
  end

  // The scan keeps one read in flight and compares its registered data with the value sought.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v       <= 1'b0;
      scan_ptr   <= '0;
      issue_left <= '0;
    end else if (cmd.scan_start) begin
      rd_v       <= 1'b0;
      scan_ptr   <= head;
      issue_left <= held;
    end else if (cmd.scan) begin
      rd_v <= scan_issue;
      if (scan_issue) begin
        scan_ptr   <= adv(scan_ptr, eff_cap);
        issue_left <= issue_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status     <= cmd.out_status;
      out_data.data       <= cmd.out_data_sel ? rd_data : '0;
      out_data.found_slot <= cmd.out_slot_sel ? SLOT_W'(rd_slot) : '0;
      out_data.count      <= held;
      out_data.is_full    <= (held == eff_cap);
      out_data.is_empty   <= (held == '0);
    end
  end

  `CQS_ASSERT(a_held_in_cap, clk, rst, held <= eff_cap, "held count exceeds capacity")
  `CQS_ASSERT(a_ptrs_in_cap, clk, rst, (CNT_W'(head) < eff_cap) && (CNT_W'(tail) < eff_cap),
              "pointer outside the ring")
  `CQS_ASSERT(a_ring_meets, clk, rst, ((held == '0) || (held == eff_cap)) |-> (head == tail),
              "head and tail disagree with the count")
  `CQS_ASSERT(a_scan_bound, clk, rst, cmd.scan_start |=> (issue_left <= eff_cap),
              "scan longer than the ring")

endmodule

FILE: src/cqs_ctrl.sv
// Controller of the circular queue: sequences each request and hands results to the output.
`timescale 1ns / 1ps
`include "circular_queue_with_search_top_macros.svh"
module cqs_ctrl import cqs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t            state, state_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_data_sel, res_data_sel_next;
  logic              res_slot_sel, res_slot_sel_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_status   <= ST_OK;
      res_data_sel <= 1'b0;
      res_slot_sel <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      res_status   <= res_status_next;
      res_data_sel <= res_data_sel_next;
      res_slot_sel <= res_slot_sel_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next        = state;
    res_status_next   = res_status;
    res_data_sel_next = res_data_sel;
    res_slot_sel_next = res_slot_sel;
    cmd               = '0;
    cmd.out_status    = res_status;
    cmd.out_data_sel  = res_data_sel;
    cmd.out_slot_sel  = res_slot_sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture       = 1'b1;
          res_status_next   = ST_OK;
          res_data_sel_next = 1'b0;
          res_slot_sel_next = 1'b0;
          state_next        = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESULT;
        unique case (stat.func) inside
          FN_ENQ: begin
            if (stat.full) begin
              res_status_next = ST_FULL;
            end else begin
              cmd.wr_enq = 1'b1;
            end
          end
          FN_DEQ, FN_PEEK: begin
            if (stat.empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              cmd.rd_head       = 1'b1;
              res_data_sel_next = 1'b1;
              state_next        = S_READ;
            end
          end
          FN_CLEAR: begin
            cmd.clear = 1'b1;
          end
          FN_SEARCH: begin
            if (stat.empty) begin
              res_status_next = ST_NOTFOUND;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            // Unused codes leave the queue alone and report ok.
          end
        endcase
      end
      S_READ: begin
        // The word at the head is in the read register now.
        cmd.deq    = (stat.func == FN_DEQ);
        state_next = S_RESULT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_hit) begin
          res_slot_sel_next = 1'b1;
          state_next        = S_RESULT;
        end else if (stat.scan_end) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CQS_ASSERT(a_load_when_free, clk, rst, cmd.load_out |-> out_free,
              "result register overwritten before it was taken")
  `CQS_ASSERT(a_accept_decode, clk, rst, (in_valid && in_ready) |=> (state == S_DECODE),
              "accepted word not decoded next cycle")
  `CQS_ASSERT(a_one_update, clk, rst,
              $onehot0({cmd.wr_enq, cmd.deq, cmd.clear, cmd.scan_start, cmd.rd_head}),
              "more than one queue update in a cycle")
  `CQS_ASSERT(a_load_then_valid, clk, rst, cmd.load_out |=> out_valid,
              "loaded result not shown")

endmodule

FILE: src/circular_queue_with_search_top.sv
// Top level of the circular queue with search: controller plus datapath.
`timescale 1ns / 1ps
// Circular FIFO of signed 32-bit words with a linear search.
// Input channel in_valid/in_ready carries one request word (func, value):
// enqueue, dequeue, peek, clear or search. Every request yields exactly one
// result word on out_valid/out_ready with status, data, found slot, count
// and full/empty flags.
// Requests are handled one at a time. From the accepting edge to out_valid:
// enqueue, clear, unused codes and failed requests pass the decode and
// result states; dequeue and peek add a read state (one synchronous read
// of the slot memory); a search adds a scan state that runs until a match
// or the last held entry (none when the queue is empty), as the scan reads
// one slot per cycle. A new request is taken once the result is registered.
// The result sits in an output register: a stalled receiver does not keep
// the next request from being taken and worked on; only its own result
// waits until the register frees.
// cfg_we writes the capacity (clamped to 1..DEPTH) and empties the queue;
// write it only while the block is idle.
// Reset empties the queue and sets capacity to 64. The slot memory is not
// cleared: entries are only read after they were written.
module circular_queue_with_search_top import cqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
